### sv/vaps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the priority voice allocator
// no dependencies

package vaps_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned POS_W = 7;
  localparam int unsigned REM_W = 40;
  localparam int unsigned NUM_W = 41;

  typedef enum logic [1:0] {
    CmdPlay    = 2'd0,
    CmdStop    = 2'd1,
    CmdStopAll = 2'd2,
    CmdAdvance = 2'd3
  } command_e;

  typedef enum logic [2:0] {
    EvStarted  = 3'd0,
    EvRejFull  = 3'd1,
    EvRejInval = 3'd2,
    EvEvicted  = 3'd3,
    EvFinished = 3'd4,
    EvStopped  = 3'd5,
    EvNotFound = 3'd6
  } event_kind_e;

  typedef enum logic [1:0] {
    CellNop    = 2'd0,
    CellRemove = 2'd1,
    CellWrite  = 2'd2,
    CellSub    = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic             fin;
    logic [31:0]      handle;
    logic [15:0]      sample;
    logic [7:0]       prio;
    logic [REM_W-1:0] rem;
  } voice_t;

  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
    voice_t           newv;
    logic [31:0]      elapsed;
  } cell_cmd_t;

endpackage

### sv/vaps_cell.sv
`timescale 1ns / 1ps
// one voice cell of the chain: holds a voice, shifts from its upper neighbour
// depends on vaps_pkg

module vaps_cell import vaps_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  voice_t    nb_i,
  output voice_t    voice_o
);

  voice_t v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      case (cmd_i.op)
        CellRemove: begin
          if (POS_W'(IDX) >= cmd_i.pos) v_q <= nb_i;
        end
        CellWrite: begin
          if (POS_W'(IDX) == cmd_i.pos) v_q <= cmd_i.newv;
        end
        CellSub: begin
          if (v_q.valid) begin
            if (v_q.rem > {8'h00, cmd_i.elapsed}) begin
              v_q.rem <= v_q.rem - {8'h00, cmd_i.elapsed};
            end else begin
              v_q.fin <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign voice_o = v_q;

endmodule

### sv/vaps_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle: ceil(dur * 256 / pitch)
// depends on vaps_pkg

module vaps_div import vaps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dur_i,
  input  logic [15:0]      pitch_i,
  output logic             busy_o,
  output logic [REM_W-1:0] quo_o
);

  logic [15:0]      rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [15:0]      den_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic [16:0]      trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    qbit  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'(NUM_W - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= pitch_i;
      quo_q <= NUM_W'({dur_i, 8'h00}) + NUM_W'(pitch_i) - NUM_W'(1);
    end else if (busy_q) begin
      rem_q <= qbit ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      quo_q <= {quo_q[NUM_W-2:0], qbit};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q[REM_W-1:0];

endmodule

### sv/voice_allocator_priority_steal.sv
`timescale 1ns / 1ps
// priority voice allocator with stealing: controller, divider and voice cell chain
// play: the started event is registered once the 41-step divider is done and the output is free
// (the victim scan of up to SLOTS cells runs alongside the divider); rejections are also events
// stop: scans the cells oldest first; stop all: one event a cycle while the output accepts
// advance: scans the cells, one event per finished voice; one command in flight at a time
// reset is asynchronous active low: no voices, limit 16, handles restart at one

module voice_allocator_priority_steal import vaps_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample_number, priority_req, duration_ticks, pitch_q8, voice_handle, elapsed_ticks
  input  logic [135:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // event_handle, event_sample, voice count, zero fill
  output logic [55:0]  m_axis_tdata,
  // event_kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PLAY  = 4'd1;
  localparam logic [3:0] S_VSCAN = 4'd2;
  localparam logic [3:0] S_EVICT = 4'd3;
  localparam logic [3:0] S_WDIV  = 4'd4;
  localparam logic [3:0] S_STOP  = 4'd5;
  localparam logic [3:0] S_ALL   = 4'd6;
  localparam logic [3:0] S_ADV   = 4'd7;

  logic [3:0]       state_q, state_d;
  logic [POS_W-1:0] cnt_q, cnt_d, p_q, p_d, best_q, best_d;
  logic [7:0]       bprio_q, bprio_d;
  logic [31:0]      nhandle_q, nhandle_d;
  logic [4:0]       limit_q;
  logic [15:0]      sample_q, pitch_q;
  logic [7:0]       prio_q;
  logic [31:0]      handle_q;

  logic             ov_q, ov_d, olast_q, olast_d;
  event_kind_e      okind_q, okind_d;
  logic [31:0]      ohandle_q, ohandle_d;
  logic [15:0]      osample_q, osample_d;
  logic [POS_W-1:0] oact_q, oact_d;

  voice_t           cells [SLOTS];
  voice_t           rd, bv;
  cell_cmd_t        ccmd;
  logic [SLOTS-1:0] valid_vec;
  logic             more_fin, can_emit, in_acc, full, div_busy;
  logic [31:0]      lim32;
  logic [REM_W-1:0] quo;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign can_emit = !ov_q || m_axis_tready;
  assign rd       = cells[p_q[IDX_W-1:0]];
  assign bv       = cells[best_q[IDX_W-1:0]];

  always_comb begin
    if (limit_q == 5'd0) lim32 = 32'd1;
    else if (32'(limit_q) > 32'(SLOTS)) lim32 = 32'(SLOTS);
    else lim32 = 32'(limit_q);
    full = 32'(cnt_q) >= lim32;
  end

  always_comb begin
    more_fin = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      valid_vec[i] = cells[i].valid;
      if (32'(i) > 32'(p_q) && cells[i].fin && cells[i].valid) more_fin = 1'b1;
    end
  end

  vaps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && s_axis_tuser == CmdPlay),
    .dur_i   (s_axis_tdata[55:24]),
    .pitch_i (s_axis_tdata[71:56]),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    voice_t nb;
    if (g == SLOTS - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cells[g+1];
    end
    vaps_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (ccmd),
      .nb_i    (nb),
      .voice_o (cells[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    p_d       = p_q;
    best_d    = best_q;
    bprio_d   = bprio_q;
    nhandle_d = nhandle_q;
    ov_d      = ov_q && !m_axis_tready;
    okind_d   = okind_q;
    ohandle_d = ohandle_q;
    osample_d = osample_q;
    oact_d    = oact_q;
    olast_d   = olast_q;
    ccmd      = '0;
    ccmd.op   = CellNop;
    ccmd.elapsed = s_axis_tdata[135:104];
    ccmd.newv.valid  = 1'b1;
    ccmd.newv.fin    = 1'b0;
    ccmd.newv.handle = nhandle_q;
    ccmd.newv.sample = sample_q;
    ccmd.newv.prio   = prio_q;
    ccmd.newv.rem    = quo;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          p_d = '0;
          case (s_axis_tuser)
            CmdPlay: state_d = S_PLAY;
            CmdStop: state_d = S_STOP;
            CmdStopAll: begin
              if (cnt_q != '0) state_d = S_ALL;
            end
            default: begin
              ccmd.op = CellSub;
              state_d = S_ADV;
            end
          endcase
        end
      end
      S_PLAY: begin
        if (pitch_q == 16'd0) begin
          if (can_emit) begin
            ov_d = 1'b1; okind_d = EvRejInval; ohandle_d = '0;
            osample_d = sample_q; oact_d = cnt_q; olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if (full) begin
          best_d  = '0;
          bprio_d = cells[0].prio;
          p_d     = POS_W'(1);
          state_d = S_VSCAN;
        end else begin
          state_d = S_WDIV;
        end
      end
      S_VSCAN: begin
        if (p_q == cnt_q) begin
          state_d = S_EVICT;
        end else begin
          if (rd.prio < bprio_q) begin
            bprio_d = rd.prio;
            best_d  = p_q;
          end
          p_d = p_q + POS_W'(1);
        end
      end
      S_EVICT: begin
        if (can_emit) begin
          ov_d = 1'b1;
          if (prio_q > bprio_q) begin
            okind_d = EvEvicted; ohandle_d = bv.handle; osample_d = bv.sample;
            oact_d = cnt_q - POS_W'(1); olast_d = 1'b0;
            ccmd.op = CellRemove; ccmd.pos = best_q;
            cnt_d = cnt_q - POS_W'(1);
            state_d = S_WDIV;
          end else begin
            okind_d = EvRejFull; ohandle_d = '0; osample_d = sample_q;
            oact_d = cnt_q; olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_WDIV: begin
        if (!div_busy && can_emit) begin
          ccmd.op = CellWrite; ccmd.pos = cnt_q;
          ov_d = 1'b1; okind_d = EvStarted; ohandle_d = nhandle_q;
          osample_d = sample_q; oact_d = cnt_q + POS_W'(1); olast_d = 1'b1;
          cnt_d = cnt_q + POS_W'(1);
          nhandle_d = (nhandle_q == 32'hFFFF_FFFF) ? 32'd1 : nhandle_q + 32'd1;
          state_d = S_IDLE;
        end
      end
      S_STOP: begin
        if (p_q == cnt_q) begin
          if (can_emit) begin
            ov_d = 1'b1; okind_d = EvNotFound; ohandle_d = handle_q;
            osample_d = '0; oact_d = cnt_q; olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if (rd.handle == handle_q) begin
          if (can_emit) begin
            ov_d = 1'b1; okind_d = EvStopped; ohandle_d = handle_q;
            osample_d = rd.sample; oact_d = cnt_q - POS_W'(1); olast_d = 1'b1;
            ccmd.op = CellRemove; ccmd.pos = p_q;
            cnt_d = cnt_q - POS_W'(1);
            state_d = S_IDLE;
          end
        end else begin
          p_d = p_q + POS_W'(1);
        end
      end
      S_ALL: begin
        if (can_emit) begin
          ov_d = 1'b1; okind_d = EvStopped; ohandle_d = cells[0].handle;
          osample_d = cells[0].sample; oact_d = cnt_q - POS_W'(1);
          olast_d = cnt_q == POS_W'(1);
          ccmd.op = CellRemove; ccmd.pos = '0;
          cnt_d = cnt_q - POS_W'(1);
          if (cnt_q == POS_W'(1)) state_d = S_IDLE;
        end
      end
      S_ADV: begin
        if (p_q == cnt_q) begin
          state_d = S_IDLE;
        end else if (rd.fin) begin
          if (can_emit) begin
            ov_d = 1'b1; okind_d = EvFinished; ohandle_d = rd.handle;
            osample_d = rd.sample; oact_d = cnt_q - POS_W'(1); olast_d = !more_fin;
            ccmd.op = CellRemove; ccmd.pos = p_q;
            cnt_d = cnt_q - POS_W'(1);
          end
        end else begin
          p_d = p_q + POS_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      p_q       <= '0;
      best_q    <= '0;
      bprio_q   <= '0;
      nhandle_q <= 32'd1;
      limit_q   <= 5'd16;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      p_q       <= p_d;
      best_q    <= best_d;
      bprio_q   <= bprio_d;
      nhandle_q <= nhandle_d;
      ov_q      <= ov_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q   <= okind_d;
    ohandle_q <= ohandle_d;
    osample_q <= osample_d;
    oact_q    <= oact_d;
    olast_q   <= olast_d;
    if (in_acc) begin
      sample_q <= s_axis_tdata[15:0];
      prio_q   <= s_axis_tdata[23:16];
      pitch_q  <= s_axis_tdata[71:56];
      handle_q <= s_axis_tdata[103:72];
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {3'b000, 5'(oact_q), osample_q, ohandle_q};

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= 32'(SLOTS)) else $error("voice count beyond slot count");

  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(valid_vec)) == 32'(cnt_q)) else $error("count and valid cells disagree");

  a_started_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == EvStarted) |-> (m_axis_tdata[31:0] != 32'd0))
    else $error("started voice with zero handle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("stalled event transfer changed");

endmodule

### sim/voice_allocator_priority_steal_chk.sv
`timescale 1ns / 1ps
// checker for the priority voice allocator: watches command, event and limit transfers,
// predicts the event stream and compares it field by field
// depends on vaps_pkg

module voice_allocator_priority_steal_chk import vaps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // sample_number, priority_req, duration_ticks, pitch_q8, voice_handle, elapsed_ticks
  input  logic [135:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // event_handle, event_sample, voice count, zero fill
  input  logic [55:0]  m_axis_tdata,
  // event_kind
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           events_o
);

  localparam int NV = 16;

  typedef struct packed {
    event_kind_e kind;
    logic [31:0] handle;
    logic [15:0] sample;
    logic [4:0]  active;
    logic        last;
  } voice_event_t;

  voice_event_t event_q[$];

  logic [4:0]  limit_reg;
  logic        live[NV];
  logic [31:0] v_handle[NV];
  logic [15:0] v_sample[NV];
  logic [7:0]  v_prio[NV];
  logic [31:0] v_order[NV];
  logic [63:0] v_rem[NV];
  logic [31:0] handle_ctr;
  logic [31:0] order_ctr;

  function automatic logic [31:0] age(int i);
    return order_ctr - v_order[i];
  endfunction

  function automatic int live_count();
    int c;
    c = 0;
    for (int i = 0; i < NV; i++) if (live[i]) c++;
    return c;
  endfunction

  task automatic post_event(event_kind_e k, logic [31:0] h, logic [15:0] s, int n);
    voice_event_t ev;
    ev.kind = k;
    ev.handle = h;
    ev.sample = s;
    ev.active = n[4:0];
    ev.last = 1'b0;
    event_q.insert(event_q.size(), ev);
  endtask

  // oldest first among the marked voices
  task automatic retire_marked(logic [NV-1:0] mark, event_kind_e k);
    int n;
    int best;
    n = live_count();
    forever begin
      best = -1;
      for (int i = 0; i < NV; i++)
        if (mark[i] && (best < 0 || age(i) > age(best))) best = i;
      if (best < 0) break;
      mark[best] = 1'b0;
      live[best] = 1'b0;
      n--;
      post_event(k, v_handle[best], v_sample[best], n);
    end
  endtask

  task automatic start_voice(logic [15:0] smp, logic [7:0] pr, logic [31:0] dur,
                             logic [15:0] pitch);
    int n;
    int lim;
    int victim;
    int slot;
    n = live_count();
    lim = limit_reg;
    victim = -1;
    slot = -1;
    if (pitch == 16'd0) begin
      post_event(EvRejInval, 32'd0, smp, n);
      return;
    end
    if (lim < 1) lim = 1;
    if (lim > NV) lim = NV;
    if (n >= lim) begin
      for (int i = 0; i < NV; i++) begin
        if (live[i] && (victim < 0 || v_prio[i] < v_prio[victim] ||
            (v_prio[i] == v_prio[victim] && age(i) > age(victim))))
          victim = i;
      end
      if (victim < 0 || pr <= v_prio[victim]) begin
        post_event(EvRejFull, 32'd0, smp, n);
        return;
      end
      live[victim] = 1'b0;
      n--;
      post_event(EvEvicted, v_handle[victim], v_sample[victim], n);
    end
    for (int i = NV - 1; i >= 0; i--) if (!live[i]) slot = i;
    if (slot < 0) begin
      post_event(EvRejFull, 32'd0, smp, n);
      return;
    end
    live[slot] = 1'b1;
    v_handle[slot] = handle_ctr;
    v_sample[slot] = smp;
    v_prio[slot] = pr;
    v_order[slot] = order_ctr;
    v_rem[slot] = (({32'd0, dur} << 8) + {48'd0, pitch} - 64'd1) / {48'd0, pitch};
    v_rem[slot] = v_rem[slot] & 64'hFF_FFFF_FFFF;
    handle_ctr++;
    if (handle_ctr == 32'd0) handle_ctr = 32'd1;
    order_ctr++;
    if (order_ctr == 32'd0) order_ctr = 32'd1;
    n++;
    post_event(EvStarted, v_handle[slot], smp, n);
  endtask

  task automatic predict_events(command_e cmd, logic [135:0] d);
    int n_prior;
    int found;
    logic [NV-1:0] mark;
    voice_event_t tail;
    n_prior = event_q.size();
    found = -1;
    mark = '0;
    case (cmd)
      CmdPlay: start_voice(d[15:0], d[23:16], d[55:24], d[71:56]);
      CmdStop: begin
        for (int i = NV - 1; i >= 0; i--)
          if (live[i] && v_handle[i] == d[103:72]) found = i;
        if (found < 0) begin
          post_event(EvNotFound, d[103:72], 16'd0, live_count());
        end else begin
          live[found] = 1'b0;
          post_event(EvStopped, d[103:72], v_sample[found], live_count());
        end
      end
      CmdStopAll: begin
        for (int i = 0; i < NV; i++) mark[i] = live[i];
        retire_marked(mark, EvStopped);
      end
      default: begin
        for (int i = 0; i < NV; i++) begin
          if (live[i]) begin
            if (v_rem[i] > {32'd0, d[135:104]}) v_rem[i] = v_rem[i] - {32'd0, d[135:104]};
            else mark[i] = 1'b1;
          end
        end
        retire_marked(mark, EvFinished);
      end
    endcase
    if (event_q.size() > n_prior) begin
      tail = event_q.pop_back();
      tail.last = 1'b1;
      event_q.insert(event_q.size(), tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    voice_event_t exp_ev;
    voice_event_t got_ev;
    if (!rst_ni) begin
      limit_reg = 5'd16;
      handle_ctr = 32'd1;
      order_ctr = 32'd1;
      for (int i = 0; i < NV; i++) live[i] = 1'b0;
      event_q.delete();
      fail_count_o = 0;
      events_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        events_o++;
        got_ev.kind = event_kind_e'(m_axis_tuser);
        got_ev.handle = m_axis_tdata[31:0];
        got_ev.sample = m_axis_tdata[47:32];
        got_ev.active = m_axis_tdata[52:48];
        got_ev.last = m_axis_tlast;
        if (event_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected event, expected none, actual %h", $time, got_ev);
        end else begin
          exp_ev = event_q.pop_front();
          if (got_ev !== exp_ev) begin
            fail_count_o++;
            $display("%0t: event mismatch, expected kind %0d handle %h sample %h active %0d last %b",
                     $time, exp_ev.kind, exp_ev.handle, exp_ev.sample, exp_ev.active,
                     exp_ev.last);
            $display("%0t:                 actual kind %0d handle %h sample %h active %0d last %b",
                     $time, got_ev.kind, got_ev.handle, got_ev.sample, got_ev.active,
                     got_ev.last);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) limit_reg = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        predict_events(command_e'(s_axis_tuser), s_axis_tdata);
      pending_o = event_q.size();
    end
  end

endmodule

### sim/tb_voice_allocator_priority_steal.sv
`timescale 1ns / 1ps
// testbench top for the priority voice allocator: directed and random commands,
// limit changes, random idling on both sides; depends on vaps_pkg and the checker

module tb_voice_allocator_priority_steal;
  import vaps_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [55:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [4:0]   cfg_data_i;
  int           fail_count;
  int           pending;
  int           events_seen;
  int           cmds_sent;
  int           plays_sent;
  logic         quiet;
  logic         hold_req;
  logic         hold_done;

  voice_allocator_priority_steal i_dut (.*);

  voice_allocator_priority_steal_chk i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .events_o(events_seen)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_cmd(command_e cmd, logic [15:0] smp, logic [7:0] pr, logic [31:0] dur,
                          logic [15:0] pitch, logic [31:0] hnd, logic [31:0] elapsed);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tuser = cmd;
    s_axis_tdata = {elapsed, hnd, pitch, dur, pr, smp};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    cmds_sent++;
    if (cmd == CmdPlay) plays_sent++;
  endtask

  task automatic play(logic [15:0] smp, logic [7:0] pr, logic [31:0] dur, logic [15:0] pitch);
    send_cmd(CmdPlay, smp, pr, dur, pitch, $urandom, $urandom);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] v);
    drain();
    cfg_data_i = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_cmd();
    int sel;
    logic [15:0] pitch;
    logic [15:0] smp;
    logic [15:0] pt;
    logic [7:0]  pr;
    logic [31:0] dur;
    logic [31:0] hnd;
    logic [31:0] el;
    sel = $urandom_range(0, 99);
    smp = 16'($urandom);
    pt = 16'($urandom);
    pr = 8'($urandom);
    if (sel < 45) begin
      case ($urandom_range(0, 9))
        0: pitch = 16'd0;
        1: pitch = 16'($urandom);
        2, 3: pitch = 16'd256;
        default: pitch = 16'($urandom_range(1, 1024));
      endcase
      dur = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000);
      if ($urandom_range(0, 1) != 0) pr = 8'($urandom_range(0, 3));
      play(smp, pr, dur, pitch);
    end else if (sel < 65) begin
      hnd = ($urandom_range(0, 7) == 0) ? $urandom
            : plays_sent + 1 - $urandom_range(0, (plays_sent < 8) ? plays_sent : 8);
      send_cmd(CmdStop, smp, pr, $urandom, pt, hnd, $urandom);
    end else if (sel < 70) begin
      send_cmd(CmdStopAll, smp, pr, $urandom, pt, $urandom, $urandom);
    end else begin
      el = ($urandom_range(0, 11) == 0) ? $urandom : $urandom_range(0, 3000);
      send_cmd(CmdAdvance, smp, pr, $urandom, pt, $urandom, el);
    end
  endtask

  // receiver side
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (quiet) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CmdPlay;
    cfg_valid_i = 1'b0;
    cfg_data_i = 5'd16;
    quiet = 1'b0;
    hold_req = 1'b0;
    cmds_sent = 0;
    plays_sent = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    play(16'h1234, 8'd9, 32'd100, 16'd0);
    send_cmd(CmdStopAll, '0, '0, '0, '0, '0, '0);
    send_cmd(CmdAdvance, '0, '0, '0, '0, '0, 32'd0);
    send_cmd(CmdStop, '0, '0, '0, '0, 32'd0, '0);
    play(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'd1);
    play(16'h0000, 8'h00, 32'd0, 16'hFFFF);
    send_cmd(CmdAdvance, '0, '0, '0, '0, '0, 32'd0);
    send_cmd(CmdStop, '0, '0, '0, '0, 32'd1, '0);
    send_cmd(CmdStop, '0, '0, '0, '0, 32'hFFFF_FFFF, '0);
    write_limit(5'd1);
    play(16'd10, 8'd5, 32'd50, 16'd256);
    play(16'd11, 8'd5, 32'd50, 16'd256);
    play(16'd12, 8'd6, 32'd50, 16'd256);
    send_cmd(CmdAdvance, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
    write_limit(5'd0);
    play(16'd20, 8'd1, 32'd5, 16'd256);
    play(16'd21, 8'd0, 32'd5, 16'd256);
    play(16'd22, 8'd2, 32'd5, 16'd256);
    write_limit(5'd31);
    play(16'd30, 8'd7, 32'd7, 16'd128);
    play(16'd31, 8'd7, 32'd9, 16'd512);
    play(16'd32, 8'd3, 32'd3, 16'd300);
    write_limit(5'd2);
    play(16'd33, 8'd255, 32'd1, 16'd256);
    send_cmd(CmdStopAll, '0, '0, '0, '0, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_limit(5'd16);
        1: write_limit(5'd4);
        2: write_limit(5'd1);
        default: write_limit(5'($urandom_range(0, 31)));
      endcase
      for (int k = 0; k < 24; k++) begin
        if (ph == 3 && k == 10) quiet = 1'b1;
        if (ph == 1 && k == 10) hold_req = 1'b1;
        if (ph == 2 && k == 15) drain();
        random_cmd();
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("run covered %0d commands and %0d events over several voice limits,",
             cmds_sent, events_seen);
    $display("with eviction, rejection, stop, stop all and advance under random idling");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
